[rtl/multichannel_sample_averager_unit_defines.svh]
// Assertion macros for the sample averager.
`ifndef MULTICHANNEL_SAMPLE_AVERAGER_UNIT_DEFINES_SVH
`define MULTICHANNEL_SAMPLE_AVERAGER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// Checked only while out of reset.
`define MSA_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every edge, reset included.
`define MSA_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MSA_ASSERT(name, prop, msg)
`define MSA_ASSERT_ALWAYS(name, prop, msg)
`endif

`endif

[rtl/msa_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package msa_pkg;

  localparam int SAMPLE_W = 12;
  localparam int WORD_W   = 32;
  localparam int CHAN_W   = 4;   // channel field of a word and read_channel
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;

  // converter word layout
  localparam int CHAN_LSB   = 26;
  localparam int SAMPLE_LSB = 4;

  // input kinds
  localparam logic KIND_WORD = 1'b0;
  localparam logic KIND_READ = 1'b1;

  // filter modes
  localparam logic MODE_RAW = 1'b0;
  localparam logic MODE_AVG = 1'b1;

  // config register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_READ_CHANNEL = 2'd1;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_LAST,
    S_DIV,
    S_OUT
  } msa_state_t;

endpackage
`default_nettype wire

[rtl/msa_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
module msa_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule
`default_nettype wire

[rtl/multichannel_sample_averager_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// Multichannel sample averager.
// Input channel (in_valid / in_stall): in_kind 0 carries a converter word
// (channel in bits 29..26, sample in bits 15..4); in_kind 1 is a read request.
// Words store the sample for their channel (raw: entry 0, average: ring slot
// at the channel's write position). Words for channels >= CHANNELS are dropped.
// A read request yields one item on out_value for cfg read_channel: raw
// sample, truncated mean of DEPTH entries, or 0 for an unknown channel.
// A word is written to the store when it is taken. A raw read fetches
// entry 0 of the sample RAM. An average read reads DEPTH entries of the
// sample RAM port, one entry a cycle, then forms the mean by a
// reciprocal multiply. A read of an unknown channel goes straight to output.
// A read holds the input until its result is loaded into the output register.
// One item is in work at a time; the next item is taken while a finished
// result still waits in the output register for the receiver.
// Reset: after rst_n the sample RAM is zeroed, one entry a cycle, over all
// CHANNELS * 2**clog2(DEPTH) entries; in_stall stays high meanwhile.
// Config writes (cfg_valid / cfg_ready) are taken any time, ready is tied high.
// out_stall holds the result in place; a finished read then waits for it.
module multichannel_sample_averager_unit
  import msa_pkg::*;
#(
  parameter int CHANNELS = 12,
  parameter int DEPTH    = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // input items
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic                  in_kind,
  input  wire logic [WORD_W-1:0]     in_result_word,
  // result items
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [SAMPLE_W-1:0]        out_value,
  // configuration
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  `include "multichannel_sample_averager_unit_defines.svh"

  // Store layout: channel-major, each channel owns 2**POS_W slots.
  localparam int POS_W     = $clog2(DEPTH);
  localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int MEM_DEPTH = CHANNELS * (2 ** POS_W);
  localparam int AW        = $clog2(MEM_DEPTH);
  localparam int SUM_W     = SAMPLE_W + POS_W + 1;
  // sum / DEPTH == (sum * RECIP) >> RECIP_SH for every sum below 2**SUM_W
  localparam int RECIP_SH  = SUM_W + POS_W;
  localparam int RECIP_W   = SUM_W + 1;
  localparam int PROD_W    = SUM_W + RECIP_W;

  localparam logic [POS_W-1:0]   POS_LAST = POS_W'(DEPTH - 1);
  localparam logic [AW-1:0]      CLR_LAST = AW'(MEM_DEPTH - 1);
  localparam logic [RECIP_W-1:0] RECIP    =
    RECIP_W'(((64'd1 << RECIP_SH) + 64'(DEPTH) - 64'd1) / 64'(DEPTH));

  msa_state_t state_r, state_nxt;

  logic                  filter_mode_r;
  logic [CHAN_W-1:0]     read_channel_r;
  logic [POS_W-1:0]      pos_r   [CHANNELS];
  logic [POS_W-1:0]      pos_nxt [CHANNELS];
  logic [AW-1:0]         clr_addr_r, clr_addr_nxt;
  logic [POS_W-1:0]      cnt_r, cnt_nxt;
  logic [SUM_W-1:0]      sum_r, sum_nxt;
  logic [SAMPLE_W-1:0]   res_r, res_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [SAMPLE_W-1:0]   out_value_r, out_value_nxt;

  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [SAMPLE_W-1:0]   mem_wdata;
  logic [AW-1:0]         mem_raddr;
  logic [SAMPLE_W-1:0]   mem_rdata;

  logic                  in_accept;
  logic                  out_load;
  logic                  last_issue;
  logic [CHAN_W-1:0]     word_ch;
  logic [CH_W-1:0]       word_idx;
  logic                  word_ok;
  logic [SAMPLE_W-1:0]   word_sample;
  logic [CH_W-1:0]       rd_idx;
  logic                  rd_ok;
  logic [PROD_W-1:0]     quot_prod;
  logic [POS_W-1:0]      wr_pos;

  // ---------------------------------------------------------------------------
  // Field decode
  // ---------------------------------------------------------------------------
  assign word_ch     = in_result_word[CHAN_LSB +: CHAN_W];
  assign word_idx    = word_ch[CH_W-1:0];
  assign word_ok     = {1'b0, word_ch} < (CHAN_W + 1)'(CHANNELS);
  assign word_sample = in_result_word[SAMPLE_LSB +: SAMPLE_W];
  assign rd_idx      = read_channel_r[CH_W-1:0];
  assign rd_ok       = {1'b0, read_channel_r} < (CHAN_W + 1)'(CHANNELS);
  assign wr_pos      = word_ok ? pos_r[word_idx] : '0;

  assign in_accept  = in_valid && !in_stall;
  assign out_load   = !out_valid_r || !out_stall;
  // raw mode reads only entry 0
  assign last_issue = (filter_mode_r == MODE_RAW) || (cnt_r == POS_LAST);
  // truncated mean by reciprocal multiply
  assign quot_prod  = PROD_W'(sum_r) * PROD_W'(RECIP);

  // ---------------------------------------------------------------------------
  // Sample store
  // ---------------------------------------------------------------------------
  msa_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (MEM_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // ---------------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_mode_r  <= MODE_RAW;
      read_channel_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_FILTER_MODE:  filter_mode_r  <= cfg_data[0];
        CFG_READ_CHANNEL: read_channel_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (clr_addr_r == CLR_LAST) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_accept && in_kind == KIND_READ) begin
          state_nxt = rd_ok ? S_READ : S_OUT;
        end
      end
      S_READ: begin
        if (last_issue) state_nxt = S_LAST;
      end
      S_LAST: begin
        state_nxt = (filter_mode_r == MODE_AVG) ? S_DIV : S_OUT;
      end
      S_DIV: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Datapath and outputs
  // ---------------------------------------------------------------------------
  always_comb begin
    in_stall      = (state_r != S_IDLE);
    clr_addr_nxt  = clr_addr_r;
    cnt_nxt       = cnt_r;
    sum_nxt       = sum_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_value_nxt = out_value_r;
    pos_nxt       = pos_r;
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = '0;
    mem_raddr     = AW'({rd_idx, cnt_r});

    case (state_r)
      S_CLEAR: begin
        mem_we       = 1'b1;
        mem_waddr    = clr_addr_r;
        clr_addr_nxt = clr_addr_r + 1'b1;
      end
      S_IDLE: begin
        if (in_accept) begin
          if (in_kind == KIND_WORD) begin
            if (word_ok) begin
              mem_we    = 1'b1;
              mem_wdata = word_sample;
              if (filter_mode_r == MODE_AVG) begin
                mem_waddr         = AW'({word_idx, wr_pos});
                pos_nxt[word_idx] = (wr_pos == POS_LAST) ? '0 : wr_pos + 1'b1;
              end else begin
                mem_waddr = AW'({word_idx, {POS_W{1'b0}}});
              end
            end
          end else begin
            cnt_nxt = '0;
            sum_nxt = '0;
            res_nxt = '0;  // unknown channel reads as zero
          end
        end
      end
      S_READ: begin
        // data of the previous issue lands now
        if (cnt_r != '0) sum_nxt = sum_r + SUM_W'(mem_rdata);
        cnt_nxt = cnt_r + 1'b1;
      end
      S_LAST: begin
        if (filter_mode_r == MODE_AVG) begin
          sum_nxt = sum_r + SUM_W'(mem_rdata);
          res_nxt = '0;
        end else begin
          res_nxt = mem_rdata;
        end
      end
      S_DIV: begin
        res_nxt = quot_prod[RECIP_SH +: SAMPLE_W];
      end
      S_OUT: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = res_r;
        end
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        pos_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
      pos_r       <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r       <= cnt_nxt;
    sum_r       <= sum_nxt;
    res_r       <= res_nxt;
    out_value_r <= out_value_nxt;
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // store writes stay inside the memory
  `MSA_ASSERT_ALWAYS(a_waddr_range, mem_we |-> ({1'b0, mem_waddr} < (AW + 1)'(MEM_DEPTH)), "store write out of range")
  // a new result appears only from the output state
  `MSA_ASSERT(a_out_from_state, $rose(out_valid_r) |-> $past(state_r == S_OUT), "result raised outside output state")
  // a stalled result stays put
  `MSA_ASSERT(a_out_hold, out_valid_r && out_stall |=> out_valid_r && $stable(out_value_r), "stalled result changed")

endmodule
`default_nettype wire

[tb/tb_multichannel_sample_averager_unit.sv]
`timescale 1ns / 1ps
module tb_multichannel_sample_averager_unit;
  import msa_pkg::*;

  localparam int CHANNELS = 12;
  localparam int DEPTH    = 16;
  // an average read covers DEPTH entries; leave some margin
  localparam int SETTLE_CYCLES = DEPTH + 25;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int RAND_PHASES   = 12;
  localparam int PHASE_ITEMS   = 80;

  // register indexes with nothing behind them
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  typedef struct packed {
    logic              kind;
    logic [WORD_W-1:0] word;
  } adc_item_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  in_kind = KIND_WORD;
  logic [WORD_W-1:0]     in_result_word = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [SAMPLE_W-1:0]   out_value;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  multichannel_sample_averager_unit #(
    .CHANNELS(CHANNELS),
    .DEPTH   (DEPTH)
  ) u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_kind       (in_kind),
    .in_result_word(in_result_word),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_value     (out_value),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Shadow of the block: per-channel sample rings, write positions and the
  // two registers. Updated at the edge where an item or a write is taken.
  // ---------------------------------------------------------------------
  logic [SAMPLE_W-1:0] ring_mem [CHANNELS][DEPTH] = '{default: '0};
  int                  ring_pos [CHANNELS] = '{default: 0};
  logic                avg_mode = MODE_RAW;
  logic [CHAN_W-1:0]   sel_channel = '0;

  adc_item_t           pending_items[$];   // items not yet taken by the block
  logic [SAMPLE_W-1:0] read_values[$];     // values owed for taken read requests

  int  errors = 0;
  int  cycle_count = 0;
  bit  quiet = 1'b0;         // no idling on either side while set
  bit  hold_pending = 1'b0;  // asks the receiver for one long hold-off
  int  send_gap = 0;
  int  stall_left = 0;
  int  hold_left = 0;

  // Taken item -> shadow update; a read request owes one value.
  function automatic void apply_item(adc_item_t it);
    logic [CHAN_W-1:0]   ch;
    logic [SAMPLE_W-1:0] smp;
    int                  sum;
    ch  = it.word[CHAN_LSB +: CHAN_W];
    smp = it.word[SAMPLE_LSB +: SAMPLE_W];
    if (it.kind == KIND_WORD) begin
      // words for channels past the last one are dropped
      if (ch < CHANNELS) begin
        if (avg_mode == MODE_RAW) begin
          ring_mem[ch][0] = smp;  // position untouched in raw mode
        end else begin
          ring_mem[ch][ring_pos[ch]] = smp;
          ring_pos[ch] = (ring_pos[ch] + 1) % DEPTH;
        end
      end
    end else if (sel_channel >= CHANNELS) begin
      read_values.push_back('0);
    end else if (avg_mode == MODE_RAW) begin
      read_values.push_back(ring_mem[sel_channel][0]);
    end else begin
      // never-written entries are zero and still count in the mean
      sum = 0;
      for (int i = 0; i < DEPTH; i++) sum += ring_mem[sel_channel][i];
      read_values.push_back(SAMPLE_W'(sum / DEPTH));
    end
  endfunction

  // Idle length: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet) return 0;
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(input string what, input logic [SAMPLE_W-1:0] got,
                                 input logic [SAMPLE_W-1:0] want);
    $display("%0t ns: %s: out_value %03h, expected %03h", $realtime, what, got, want);
    errors++;
  endtask

  // ---------------------------------------------------------------------
  // Sender: offers the oldest pending item; the payload holds while stalled.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        apply_item('{in_kind, in_result_word});
        void'(pending_items.pop_front());
        send_gap = pick_gap();
      end
      if (in_valid && in_stall) begin
        // keep offering the same item
      end else if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        in_valid       <= 1'b1;
        in_kind        <= pending_items[0].kind;
        in_result_word <= pending_items[0].word;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Receiver: checks each taken value against the oldest one owed, and
  // drives out_stall with random gaps plus an occasional long hold-off.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (read_values.size() == 0) begin
          report_mismatch("result with no read request pending", out_value, '0);
        end else if (out_value !== read_values[0]) begin
          report_mismatch("value mismatch", out_value, read_values.pop_front());
        end else begin
          void'(read_values.pop_front());
        end
      end
      if (hold_pending) begin
        hold_left = 250;
        hold_pending = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        stall_left = ($urandom_range(0, 2) == 0) ? pick_gap() : 0;
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_multichannel_sample_averager_unit: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers. Call only right after a rising edge.
  // ---------------------------------------------------------------------
  task automatic add_item(input logic kind, input logic [WORD_W-1:0] word);
    pending_items.push_back('{kind, word});
  endtask

  task automatic add_read();
    add_item(KIND_READ, $urandom());  // word bits are don't-care on a read
  endtask

  task automatic add_word(input logic [CHAN_W-1:0] ch, input logic [SAMPLE_W-1:0] smp);
    logic [WORD_W-1:0] w;
    w = $urandom();
    w[CHAN_LSB +: CHAN_W]     = ch;
    w[SAMPLE_LSB +: SAMPLE_W] = smp;
    add_item(KIND_WORD, w);
  endtask

  // Everything sent and answered, then room for a trailing word to land.
  task automatic drain();
    do @(posedge clk);
    while (pending_items.size() != 0 || in_valid || read_values.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk);
    while (!cfg_ready);
    case (idx)
      CFG_FILTER_MODE:  avg_mode = data[0];
      CFG_READ_CHANNEL: sel_channel = data;
      default: ;  // unmapped index, no effect
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------
  initial begin
    int                    r;
    logic [CHAN_W-1:0]     ch;
    logic [SAMPLE_W-1:0]   smp;
    logic                  mode;
    logic [CFG_DATA_W-1:0] rc;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // writes to unmapped indexes must not disturb anything
    write_reg(CFG_SPARE_A, 4'hF);
    write_reg(CFG_SPARE_B, 4'hA);

    // raw mode, channel 0: cleared store, full-scale, ignored channels
    add_read();
    add_item(KIND_WORD, 32'hC3FF_FFFF);  // ch 0, sample FFF, other bits set
    add_read();
    add_item(KIND_WORD, 32'hFFFF_FFFF);  // ch 15, dropped
    add_word(4'd12, 12'h555);            // first channel past the end, dropped
    add_read();
    add_item(KIND_WORD, 32'hC3FF_000F);  // ch 0, sample 0, other bits set
    add_read();
    add_word(4'd11, 12'hABC);
    add_word(4'd5, 12'h123);

    // last channel, then read channels out of range
    drain();
    write_reg(CFG_READ_CHANNEL, 4'd11);
    add_read();
    drain();
    write_reg(CFG_READ_CHANNEL, 4'd12);
    add_read();
    drain();
    write_reg(CFG_READ_CHANNEL, 4'd15);
    add_read();

    // average over a partly filled ring
    drain();
    write_reg(CFG_FILTER_MODE, 4'h1);
    write_reg(CFG_READ_CHANNEL, 4'd0);
    repeat (3) add_word(4'd0, 12'hFFF);
    add_read();

    // upper data bits ignored -> raw; raw write leaves ring position alone
    drain();
    write_reg(CFG_FILTER_MODE, 4'hE);
    add_read();
    add_word(4'd0, 12'h001);
    add_read();
    drain();
    write_reg(CFG_FILTER_MODE, 4'h1);
    add_read();

    // random phases, fresh register settings each time
    for (int p = 0; p < RAND_PHASES; p++) begin
      drain();
      mode = (p == 0) ? MODE_RAW : (p == 1 || p == 7) ? MODE_AVG : 1'($urandom_range(0, 1));
      if (p == 1) rc = 4'd0;
      else if (p == 3) rc = 4'd11;
      else if (p == 4) rc = 4'd15;
      else if ($urandom_range(0, 99) < 85 || p == 7) rc = 4'($urandom_range(0, CHANNELS - 1));
      else rc = 4'($urandom_range(CHANNELS, 15));
      write_reg(CFG_FILTER_MODE, {3'($urandom_range(0, 7)), mode});
      write_reg(CFG_READ_CHANNEL, rc);
      quiet = (p == 5);
      // long receiver hold-off while the sender keeps going: block backs up
      if (p == 2) hold_pending = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        r = $urandom_range(0, 99);
        if (r < 25) begin
          add_read();
        end else begin
          // favor the read channel so its ring fills and wraps
          r = $urandom_range(0, 99);
          if (r < 50 && rc < CHANNELS) ch = rc;
          else if (r < 90) ch = 4'($urandom_range(0, CHANNELS - 1));
          else ch = 4'($urandom_range(CHANNELS, 15));
          r = $urandom_range(0, 99);
          if (p == 7 || r < 15) smp = 12'hFFF;
          else if (r < 25) smp = '0;
          else smp = 12'($urandom());
          add_word(ch, smp);
        end
      end
    end

    drain();
    if (errors == 0 && read_values.size() == 0) begin
      $display("tb_multichannel_sample_averager_unit: PASS");
    end else begin
      $display("tb_multichannel_sample_averager_unit: FAIL");
    end
    $finish;
  end

endmodule
